// ===== src/bli_pkg.sv =====
// Shared types and constants for the battery level interpolator.
// Holds the two fixed charge curves, the controller state type and the
// command/status structs. No dependencies.
package bli_pkg;

  localparam int CURVE_POINTS = 21;
  localparam int IDX_W        = $clog2(CURVE_POINTS);
  localparam int VOLT_W       = 16;
  localparam int PCT_W        = 7;
  localparam int NUM_W        = VOLT_W + 3;  // holds 5 * (v - lo)
  localparam int QUOT_W       = 3;           // quotient 0..5

  localparam logic [IDX_W-1:0]  IDX_FIRST  = IDX_W'(1);
  localparam logic [IDX_W-1:0]  IDX_LAST   = IDX_W'(CURVE_POINTS - 1);
  localparam logic [IDX_W-1:0]  IDX_SRCH_MAX = IDX_W'(CURVE_POINTS - 1);
  localparam logic [QUOT_W-1:0] QUOT_MAX   = QUOT_W'(5);
  localparam logic [PCT_W-1:0]  PCT_EMPTY  = PCT_W'(0);
  localparam logic [PCT_W-1:0]  PCT_FULL   = PCT_W'(100);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_DIVIDE,
    ST_FINISH
  } bli_state_t;

  typedef struct packed {
    logic load;         // capture the input item
    logic init_search;  // start segment search at point 1
    logic step_search;  // advance to next point
    logic init_div;     // set up numerator and span
    logic step_div;     // one subtract step
    logic set_zero;     // result 0 percent
    logic set_full;     // result 100 percent
    logic set_interp;   // result from segment and quotient
    logic load_out;     // move result to output register
  } bli_cmd_t;

  typedef struct packed {
    logic le_first;     // sample at or below first point
    logic ge_last;      // sample at or above last point
    logic search_done;  // current point is the segment end
    logic div_done;     // quotient complete
  } bli_sts_t;

  // Curve voltages in 0.1 mV, points at 0, 5, ... 100 percent.
  function automatic logic [VOLT_W-1:0] curve_point(input logic fly,
                                                    input logic [IDX_W-1:0] idx);
    logic [VOLT_W-1:0] p;
    p = '0;
    if (!fly) begin
      case (idx)
        5'd0:  p = 16'd32700;
        5'd1:  p = 16'd36100;
        5'd2:  p = 16'd36900;
        5'd3:  p = 16'd37100;
        5'd4:  p = 16'd37300;
        5'd5:  p = 16'd37500;
        5'd6:  p = 16'd37700;
        5'd7:  p = 16'd37900;
        5'd8:  p = 16'd38000;
        5'd9:  p = 16'd38200;
        5'd10: p = 16'd38400;
        5'd11: p = 16'd38500;
        5'd12: p = 16'd38700;
        5'd13: p = 16'd39100;
        5'd14: p = 16'd39500;
        5'd15: p = 16'd39800;
        5'd16: p = 16'd40200;
        5'd17: p = 16'd40800;
        5'd18: p = 16'd41100;
        5'd19: p = 16'd41500;
        5'd20: p = 16'd42000;
        default: p = 16'd42000;
      endcase
    end else begin
      case (idx)
        5'd0:  p = 16'd24000;
        5'd1:  p = 16'd29357;
        5'd2:  p = 16'd32400;
        5'd3:  p = 16'd32650;
        5'd4:  p = 16'd32800;
        5'd5:  p = 16'd32900;
        5'd6:  p = 16'd33000;
        5'd7:  p = 16'd33500;
        5'd8:  p = 16'd33667;
        5'd9:  p = 16'd33900;
        5'd10: p = 16'd33971;
        5'd11: p = 16'd34075;
        5'd12: p = 16'd34200;
        5'd13: p = 16'd34580;
        5'd14: p = 16'd34767;
        5'd15: p = 16'd34933;
        5'd16: p = 16'd35375;
        5'd17: p = 16'd36125;
        5'd18: p = 16'd36750;
        5'd19: p = 16'd37375;
        5'd20: p = 16'd38000;
        default: p = 16'd38000;
      endcase
    end
    return p;
  endfunction

endpackage

// ===== src/bli_in_if.sv =====
// Input channel: one voltage sample and curve select per item.
// Depends on bli_pkg for field widths.
interface bli_in_if;
  logic                        valid;
  logic                        ready;
  logic [bli_pkg::VOLT_W-1:0]  battery_voltage;
  logic                        in_flight;

  modport source (output valid, output battery_voltage, output in_flight, input ready);
  modport sink   (input valid, input battery_voltage, input in_flight, output ready);
endinterface

// ===== src/bli_out_if.sv =====
// Result channel: one charge level per item.
// Depends on bli_pkg for field widths.
interface bli_out_if;
  logic                       valid;
  logic                       ready;
  logic [bli_pkg::PCT_W-1:0]  battery_percent;

  modport source (output valid, output battery_percent, input ready);
  modport sink   (input valid, input battery_percent, output ready);
endinterface

// ===== src/bli_datapath.sv =====
// Datapath: sample registers, segment search index, repeated-subtract
// divider and output payload register. Uses bli_pkg.
module bli_datapath (
  input  logic                        clk,
  input  logic [bli_pkg::VOLT_W-1:0]  in_voltage,
  input  logic                        in_fly,
  input  bli_pkg::bli_cmd_t           cmd,
  output bli_pkg::bli_sts_t           sts,
  output logic [bli_pkg::PCT_W-1:0]   out_pct
);

  logic [bli_pkg::VOLT_W-1:0] volt_r;
  logic                       fly_r;
  logic [bli_pkg::IDX_W-1:0]  idx_r;
  logic [bli_pkg::NUM_W-1:0]  num_r;
  logic [bli_pkg::VOLT_W-1:0] span_r;
  logic [bli_pkg::QUOT_W-1:0] quot_r;
  logic [bli_pkg::PCT_W-1:0]  res_r;
  logic [bli_pkg::PCT_W-1:0]  out_pct_r;

  logic [bli_pkg::VOLT_W-1:0] p_first, p_last, p_cur, p_prev;
  logic [bli_pkg::VOLT_W-1:0] diff;
  logic [bli_pkg::NUM_W-1:0]  diff_x5;
  logic [bli_pkg::NUM_W-1:0]  span_ext;
  logic [bli_pkg::PCT_W-1:0]  seg_base;
  logic [bli_pkg::PCT_W-1:0]  seg_x5;
  logic [bli_pkg::QUOT_W-1:0] quot_eff;

  assign p_first = bli_pkg::curve_point(fly_r, '0);
  assign p_last  = bli_pkg::curve_point(fly_r, bli_pkg::IDX_LAST);
  assign p_cur   = bli_pkg::curve_point(fly_r, idx_r);
  assign p_prev  = bli_pkg::curve_point(fly_r, idx_r - bli_pkg::IDX_W'(1));

  assign diff     = volt_r - p_prev;
  assign diff_x5  = bli_pkg::NUM_W'({diff, 2'b00}) + bli_pkg::NUM_W'(diff);
  assign span_ext = bli_pkg::NUM_W'(span_r);

  // 5 * (idx - 1) + quotient; a zero-width segment counts as a full step
  assign seg_base = bli_pkg::PCT_W'(idx_r - bli_pkg::IDX_W'(1));
  assign seg_x5   = {seg_base[bli_pkg::PCT_W-3:0], 2'b00} + seg_base;
  assign quot_eff = (span_r == '0) ? bli_pkg::QUOT_MAX : quot_r;

  assign sts.le_first    = (volt_r <= p_first);
  assign sts.ge_last     = (volt_r >= p_last);
  assign sts.search_done = (idx_r == bli_pkg::IDX_SRCH_MAX) || (p_cur >= volt_r);
  assign sts.div_done    = (span_r == '0) || (num_r < span_ext) ||
                           (quot_r == bli_pkg::QUOT_MAX);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      volt_r <= in_voltage;
      fly_r  <= in_fly;
    end
    if (cmd.init_search) begin
      idx_r <= bli_pkg::IDX_FIRST;
    end else if (cmd.step_search) begin
      idx_r <= idx_r + bli_pkg::IDX_W'(1);
    end
    if (cmd.init_div) begin
      num_r  <= diff_x5;
      span_r <= p_cur - p_prev;
      quot_r <= '0;
    end else if (cmd.step_div) begin
      num_r  <= num_r - span_ext;
      quot_r <= quot_r + bli_pkg::QUOT_W'(1);
    end
    if (cmd.set_zero) begin
      res_r <= bli_pkg::PCT_EMPTY;
    end else if (cmd.set_full) begin
      res_r <= bli_pkg::PCT_FULL;
    end else if (cmd.set_interp) begin
      res_r <= seg_x5 + bli_pkg::PCT_W'(quot_eff);
    end
    if (cmd.load_out) begin
      out_pct_r <= res_r;
    end
  end

  assign out_pct = out_pct_r;

endmodule

// ===== src/bli_ctrl.sv =====
// Controller: sequences range check, segment search and divide for one
// item, and owns the output valid flag. Uses bli_pkg.
module bli_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  bli_pkg::bli_sts_t  sts,
  output bli_pkg::bli_cmd_t  cmd
);

  bli_pkg::bli_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bli_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      bli_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = bli_pkg::ST_CHECK;
        end
      end
      bli_pkg::ST_CHECK: begin
        if (sts.le_first) begin
          cmd.set_zero = 1'b1;
          state_nxt    = bli_pkg::ST_FINISH;
        end else if (sts.ge_last) begin
          cmd.set_full = 1'b1;
          state_nxt    = bli_pkg::ST_FINISH;
        end else begin
          cmd.init_search = 1'b1;
          state_nxt       = bli_pkg::ST_SEARCH;
        end
      end
      bli_pkg::ST_SEARCH: begin
        if (sts.search_done) begin
          cmd.init_div = 1'b1;
          state_nxt    = bli_pkg::ST_DIVIDE;
        end else begin
          cmd.step_search = 1'b1;
        end
      end
      bli_pkg::ST_DIVIDE: begin
        if (sts.div_done) begin
          cmd.set_interp = 1'b1;
          state_nxt      = bli_pkg::ST_FINISH;
        end else begin
          cmd.step_div = 1'b1;
        end
      end
      bli_pkg::ST_FINISH: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = bli_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bli_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/battery_level_interpolator_top.sv =====
// Top level of the battery level interpolator.
// Depends on bli_pkg, bli_in_if, bli_out_if, bli_ctrl and bli_datapath.
//
// Usage:
//   in_ch  (valid/ready) carries one item: a 16-bit voltage sample in
//          0.1 mV units and an in_flight bit that picks the flying curve
//          (1) or the resting curve (0).
//   out_ch (valid/ready) returns one item per input: the charge level,
//          0..100 percent, truncated to whole percent.
// Sequence (one item at a time):
//   A sample at or outside the curve ends: range check, then output load.
//   Inside: range check, linear search, repeated-subtract divide, output
//   load. The search length sets the worst case.
//   in_ch.ready rises the cycle after the result is loaded; a new item is
//   taken only once the last result has been moved to the output register.
// Reset (rst_n low, synchronous): controller returns to idle and the
//   output register is emptied; nothing else is kept between items.
// Stall: a waiting result sits in the output register while the next item
//   is accepted and processed; its result waits in the final state.
module battery_level_interpolator_top (
  input  logic         clk,
  input  logic         rst_n,
  bli_in_if.sink       in_ch,
  bli_out_if.source    out_ch
);

  bli_pkg::bli_cmd_t cmd;
  bli_pkg::bli_sts_t sts;

  // sequencing: range check, search, divide, output handoff
  bli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // curve tables, index, divider and output payload
  bli_datapath u_dp (
    .clk        (clk),
    .in_voltage (in_ch.battery_voltage),
    .in_fly     (in_ch.in_flight),
    .cmd        (cmd),
    .sts        (sts),
    .out_pct    (out_ch.battery_percent)
  );

endmodule
